[rtl/rrp_pkg.sv]
// Package for the request parser: phase and event codes, error codes and
// shared constants. Used by every module of the block; depends on nothing.
package rrp_pkg;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_INLINE = 3'd1,
      PH_COUNT  = 3'd2,
      PH_HEADER = 3'd3,
      PH_BULK   = 3'd4,
      PH_ERROR  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_BYTE    = 2'd0,
      EV_ARG_END = 2'd1,
      EV_CMD_END = 2'd2,
      EV_ERROR   = 2'd3
   } event_type;

   typedef enum logic [3:0] {
      ERR_EMPTY      = 4'd0,
      ERR_ARRAY_LEN  = 4'd1,
      ERR_EXP_BULK   = 4'd2,
      ERR_BULK_LEN   = 4'd3,
      ERR_TOO_LARGE  = 4'd4,
      ERR_BULK_TERM  = 4'd5,
      ERR_ESCAPE     = 4'd6,
      ERR_QUOTE      = 4'd7,
      ERR_ARG_COUNT  = 4'd8
   } err_type;

   localparam int DEFAULT_MAX_ARGS = 4096;
   localparam int CNT_W = 13;
   localparam logic [31:0] FRAME_LIMIT_RESET = 32'h2000_0000;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_MINUS  = 8'h2D;

   typedef struct packed {
      event_type  kind;
      logic [7:0] data;
      err_type    code;
   } result_type;

endpackage

[rtl/rrp_out_queue.sv]
// Two-entry result queue between the parser core and the result port.
// Depends on rrp_pkg for the result record type.
module rrp_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  logic [1:0]          push_count,
   input  rrp_pkg::result_type push_data0,
   input  rrp_pkg::result_type push_data1,
   output logic                can_push,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrp_pkg::result_type rsp_data,
   output logic                rsp_last
);
   import rrp_pkg::*;

   result_type e0_ff, e0_in, e1_ff, e1_in;
   logic       l0_ff, l0_in, l1_ff, l1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = e0_ff;
   assign rsp_last  = l0_ff;
   assign can_push  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      l0_in  = l0_ff;
      l1_in  = l1_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         e0_in  = e1_ff;
         l0_in  = l1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
      if (push_valid && push_count != 2'd0) begin
         if (cnt_in == 2'd0) begin
            e0_in = push_data0;
            l0_in = (push_count == 2'd1);
            e1_in = push_data1;
            l1_in = 1'b1;
         end else begin
            e1_in = push_data0;
            l1_in = 1'b1;
         end
         cnt_in = cnt_in + push_count;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
      l0_ff <= l0_in;
      l1_ff <= l1_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

[rtl/resp_request_parser.sv]
// Top level of the request parser: input register, parser state and result queue.
// Depends on rrp_pkg and rrp_out_queue.
// The parser takes one request byte per cycle while req_stall is low and reports
// argument bytes, end-of-argument, end-of-command and error items on the result
// port; a taken byte is held in the input register before its items are queued.
// A byte that yields two items fills the two-entry result queue and holds the
// input until it drains. After an error the parser drops all bytes silently until
// reset. The user must write frame_limit only while idle; no check enforces it.
module resp_request_parser #(
   parameter int MAX_ARGS = rrp_pkg::DEFAULT_MAX_ARGS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [31:0] csr_frame_limit
);
   import rrp_pkg::*;

   localparam logic [CNT_W-1:0] MAXA = CNT_W'(MAX_ARGS);
   localparam logic [CNT_W:0]   MAXW = (CNT_W+1)'(MAX_ARGS);

   logic [31:0]      limit_ff;
   logic             iv_ff;
   logic [7:0]       ib_ff;
   phase_type        ph_ff, ph_in;
   logic             cr_ff, cr_in, esc_ff, esc_in, ws_ff, ws_in, hm_ff, hm_in;
   logic [1:0]       qk_ff, qk_in;
   logic [CNT_W:0]   ac_ff, ac_in;
   logic [CNT_W-1:0] ar_ff, ar_in;
   logic [32:0]      nv_ff, nv_in;
   logic [2:0]       nf_ff, nf_in;
   logic [31:0]      br_ff, br_in, fb_ff, fb_in;

   result_type       r0, r1;
   logic [1:0]       rn;
   logic             can_push, take;
   result_type       q_data;

   assign req_stall = iv_ff && !can_push;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (take) ib_ff <= req_in_byte;
      if (reset) begin
         limit_ff <= FRAME_LIMIT_RESET;
         iv_ff    <= 1'b0;
         ph_ff    <= PH_START;
         cr_ff    <= 1'b0;
         esc_ff   <= 1'b0;
         ws_ff    <= 1'b0;
         hm_ff    <= 1'b0;
         qk_ff    <= 2'd0;
         ac_ff    <= '0;
         ar_ff    <= '0;
         nv_ff    <= '0;
         nf_ff    <= '0;
         br_ff    <= '0;
         fb_ff    <= '0;
      end else begin
         if (csr_write) limit_ff <= csr_frame_limit;
         if (!req_stall) iv_ff <= req_valid;
         ph_ff  <= ph_in;
         cr_ff  <= cr_in;
         esc_ff <= esc_in;
         ws_ff  <= ws_in;
         hm_ff  <= hm_in;
         qk_ff  <= qk_in;
         ac_ff  <= ac_in;
         ar_ff  <= ar_in;
         nv_ff  <= nv_in;
         nf_ff  <= nf_in;
         br_ff  <= br_in;
         fb_ff  <= fb_in;
      end
   end

   logic [7:0]  c, cc;
   logic        do_content, num_ok, cr_byte;
   logic [36:0] nmul;
   logic [7:0]  m;
   logic [33:0] need;
   logic [32:0] room;

   always_comb begin
      ph_in = ph_ff; cr_in = cr_ff; esc_in = esc_ff; ws_in = ws_ff; hm_in = hm_ff;
      qk_in = qk_ff; ac_in = ac_ff; ar_in = ar_ff; nv_in = nv_ff; nf_in = nf_ff;
      br_in = br_ff; fb_in = fb_ff;
      r0 = '0; r1 = '0; rn = 2'd0;
      c = ib_ff; cc = 8'd0; do_content = 1'b0; cr_byte = 1'b0; nmul = '0; m = 8'd0;
      num_ok = !nf_ff[2] && nf_ff[0] && !(nf_ff[1] && nv_ff != 33'd0);
      need = {1'b0, nv_ff} + 34'd2;
      room = {1'b0, limit_ff} - {1'b0, fb_ff} - 33'd1;
      if (iv_ff && can_push && ph_ff != PH_ERROR) begin
         if ({1'b0, fb_ff} + 33'd1 > {1'b0, limit_ff}) begin
            r0 = '{EV_ERROR, 8'd0, ERR_TOO_LARGE}; rn = 2'd1; ph_in = PH_ERROR;
         end else begin
            fb_in = fb_ff + 32'd1;
            if (ph_ff == PH_BULK) begin
               if (br_ff > 32'd2) begin
                  r0 = '{EV_BYTE, c, ERR_EMPTY}; rn = 2'd1; br_in = br_ff - 32'd1;
               end else if (br_ff == 32'd2) begin
                  cr_in = (c == CH_CR); br_in = br_ff - 32'd1;
               end else if (br_ff == 32'd1 && cr_ff && c == CH_LF) begin
                  br_in = '0;
                  r0 = '{EV_ARG_END, 8'd0, ERR_EMPTY}; rn = 2'd1;
                  ar_in = ar_ff - CNT_W'(1);
                  if (ar_in == '0) begin
                     r1 = '{EV_CMD_END, 8'd0, ERR_EMPTY}; rn = 2'd2;
                     fb_in = '0; ph_in = PH_START;
                  end else begin
                     ph_in = PH_HEADER;
                  end
                  cr_in = 1'b0; esc_in = 1'b0; qk_in = 2'd0; ws_in = 1'b0;
                  hm_in = 1'b0; nv_in = '0; nf_in = '0;
               end else begin
                  r0 = '{EV_ERROR, 8'd0, ERR_BULK_TERM}; rn = 2'd1; ph_in = PH_ERROR;
               end
            end else if (cr_ff && c == CH_LF) begin
               cr_in = 1'b0;
               case (ph_ff)
                  PH_START: begin
                     r0 = '{EV_ERROR, 8'd0, ERR_EMPTY}; rn = 2'd1; ph_in = PH_ERROR;
                  end
                  PH_INLINE: begin
                     if (esc_ff) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_ESCAPE}; rn = 2'd1; ph_in = PH_ERROR;
                     end else if (qk_ff != 2'd0) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_QUOTE}; rn = 2'd1; ph_in = PH_ERROR;
                     end else begin
                        if (ws_ff) begin
                           r0 = '{EV_ARG_END, 8'd0, ERR_EMPTY}; rn = 2'd1;
                           if (ac_ff <= MAXW) ac_in = ac_ff + (CNT_W+1)'(1);
                        end
                        if (ac_in == '0 || ac_in > MAXW) begin
                           if (rn == 2'd1) r1 = '{EV_ERROR, 8'd0, ERR_ARG_COUNT};
                           else r0 = '{EV_ERROR, 8'd0, ERR_ARG_COUNT};
                           rn = rn + 2'd1; ph_in = PH_ERROR;
                        end else begin
                           if (rn == 2'd1) r1 = '{EV_CMD_END, 8'd0, ERR_EMPTY};
                           else r0 = '{EV_CMD_END, 8'd0, ERR_EMPTY};
                           rn = rn + 2'd1; fb_in = '0; ph_in = PH_START;
                           esc_in = 1'b0; qk_in = 2'd0; ws_in = 1'b0;
                           hm_in = 1'b0; nv_in = '0; nf_in = '0;
                        end
                     end
                  end
                  PH_COUNT: begin
                     if (!num_ok || nv_ff < 33'd1 || nv_ff > {20'd0, MAXA}) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_ARRAY_LEN}; rn = 2'd1; ph_in = PH_ERROR;
                     end else begin
                        ar_in = nv_ff[CNT_W-1:0]; ph_in = PH_HEADER;
                        esc_in = 1'b0; qk_in = 2'd0; ws_in = 1'b0;
                        hm_in = 1'b0; nv_in = '0; nf_in = '0;
                     end
                  end
                  default: begin
                     if (!hm_ff) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_EXP_BULK}; rn = 2'd1; ph_in = PH_ERROR;
                     end else if (!num_ok || nv_ff > {1'b0, limit_ff}) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_BULK_LEN}; rn = 2'd1; ph_in = PH_ERROR;
                     end else if (need > {1'b0, room}) begin
                        r0 = '{EV_ERROR, 8'd0, ERR_TOO_LARGE}; rn = 2'd1; ph_in = PH_ERROR;
                     end else begin
                        br_in = need[31:0]; ph_in = PH_BULK;
                        esc_in = 1'b0; qk_in = 2'd0; ws_in = 1'b0;
                        hm_in = 1'b0; nv_in = '0; nf_in = '0;
                     end
                  end
               endcase
            end else begin
               // A held CR that is not followed by LF is content; the
               // two-byte case can only yield one result before this byte.
               if (cr_ff) begin
                  cr_byte = 1'b1;
               end
               cr_in = (c == CH_CR);
               do_content = 1'b1;
            end
         end
      end

      // Content path: up to two content bytes (held CR, then this byte).
      if (do_content) begin
         for (int k = 0; k < 2; k++) begin
            if ((k == 0 && cr_byte) || (k == 1 && c != CH_CR)) begin
               cc = (k == 0) ? CH_CR : c;
               if (ph_in == PH_START) begin
                  if (cc == CH_STAR) begin
                     ph_in = PH_COUNT;
                  end else begin
                     ph_in = PH_INLINE; ac_in = '0;
                  end
               end
               if (ph_in == PH_INLINE && !(ph_ff == PH_START && k == 0 && cc == CH_STAR)) begin
                  m = cc;
                  if (esc_in) begin
                     esc_in = 1'b0;
                     if (cc == 8'h6E) m = CH_LF;
                     else if (cc == 8'h72) m = CH_CR;
                     else if (cc == 8'h74) m = CH_TAB;
                     if (rn == 2'd0) r0 = '{EV_BYTE, m, ERR_EMPTY};
                     else r1 = '{EV_BYTE, m, ERR_EMPTY};
                     rn = rn + 2'd1; ws_in = 1'b1;
                  end else if (cc == CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else if (qk_in != 2'd0) begin
                     if ((qk_in == 2'd1 && cc == CH_SQUOTE) ||
                         (qk_in == 2'd2 && cc == CH_DQUOTE)) begin
                        qk_in = 2'd0;
                     end else begin
                        if (rn == 2'd0) r0 = '{EV_BYTE, cc, ERR_EMPTY};
                        else r1 = '{EV_BYTE, cc, ERR_EMPTY};
                        rn = rn + 2'd1;
                     end
                  end else if (cc == CH_SQUOTE) begin
                     qk_in = 2'd1; ws_in = 1'b1;
                  end else if (cc == CH_DQUOTE) begin
                     qk_in = 2'd2; ws_in = 1'b1;
                  end else if (cc == CH_SPACE || cc == CH_TAB) begin
                     if (ws_in) begin
                        if (rn == 2'd0) r0 = '{EV_ARG_END, 8'd0, ERR_EMPTY};
                        else r1 = '{EV_ARG_END, 8'd0, ERR_EMPTY};
                        rn = rn + 2'd1;
                        if (ac_in <= MAXW) ac_in = ac_in + (CNT_W+1)'(1);
                        ws_in = 1'b0;
                     end
                  end else begin
                     if (rn == 2'd0) r0 = '{EV_BYTE, cc, ERR_EMPTY};
                     else r1 = '{EV_BYTE, cc, ERR_EMPTY};
                     rn = rn + 2'd1; ws_in = 1'b1;
                  end
               end else if (ph_in == PH_COUNT && !(ph_ff == PH_START && k == 0)
                            && !(ph_ff == PH_START && cc == CH_STAR)) begin
                  if (!nf_in[2]) begin
                     if (nf_in == 3'd0 && cc == CH_MINUS) begin
                        nf_in[1] = 1'b1;
                     end else if (cc >= 8'h30 && cc <= 8'h39) begin
                        nf_in[0] = 1'b1;
                        nmul = {nv_in, 3'b000} + {3'b000, nv_in, 1'b0}
                               + {29'd0, cc - 8'h30};
                        if (nmul > 37'h1_0000_0000) nv_in = 33'h1_0000_0000;
                        else nv_in = nmul[32:0];
                     end else begin
                        nf_in[2] = 1'b1;
                     end
                  end
               end else if (ph_in == PH_HEADER) begin
                  if (!hm_in && !nf_in[2]) begin
                     if (cc == CH_DOLLAR) hm_in = 1'b1;
                     else nf_in[2] = 1'b1;
                  end else if (!nf_in[2]) begin
                     if (nf_in == 3'd0 && cc == CH_MINUS) begin
                        nf_in[1] = 1'b1;
                     end else if (cc >= 8'h30 && cc <= 8'h39) begin
                        nf_in[0] = 1'b1;
                        nmul = {nv_in, 3'b000} + {3'b000, nv_in, 1'b0}
                               + {29'd0, cc - 8'h30};
                        if (nmul > 37'h1_0000_0000) nv_in = 33'h1_0000_0000;
                        else nv_in = nmul[32:0];
                     end else begin
                        nf_in[2] = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   rrp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (iv_ff && can_push),
      .push_count (rn),
      .push_data0 (r0),
      .push_data1 (r1),
      .can_push   (can_push),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (q_data),
      .rsp_last   (rsp_last)
   );

   assign rsp_event_kind = q_data.kind;
   assign rsp_data_byte  = q_data.data;
   assign rsp_error_code = q_data.code;
endmodule
